[hw/rtl/bhs_pkg.sv]
// Shared types and constants for the bucketed hash set core.
// Holds command, status and sequencer codes; no dependencies.
package bhs_pkg;

	localparam int NUM_BUCKETS_DEF  = 10;
	localparam int BUCKET_DEPTH_DEF = 8;
	localparam int KEY_W            = 32;
	localparam int BIDX_W           = 6;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_ALTER  = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_K,
		S_MUL_R,
		S_RD_NB,
		S_CMP_NB,
		S_CMP_B,
		S_WR_NB
	} state_t;

endpackage

[hw/rtl/bhs_hash.sv]
// Bucket hash: key mod NUM_BUCKETS by reciprocal multiply and one correction.
// Two stages: registered product, then remainder out combinationally.
// Depends on bhs_pkg.
module bhs_hash #(
	parameter int NUM_BUCKETS = bhs_pkg::NUM_BUCKETS_DEF,
	localparam int RAW = $clog2(NUM_BUCKETS)
) (
	input  logic                     clk,
	input  logic [bhs_pkg::KEY_W-1:0] op,
	output logic [RAW-1:0]           rem
);
	localparam int KW    = bhs_pkg::KEY_W;
	localparam int SHIFT = KW + RAW;
	localparam int PW    = KW + 33;
	// floor(2^SHIFT / N) always fits in 33 bits
	localparam logic [32:0] RECIP = 33'((64'd1 << SHIFT) / 64'(NUM_BUCKETS));
	localparam logic [RAW:0] NB_C = (RAW + 1)'(NUM_BUCKETS);

	logic [PW-1:0] prod_s1;
	logic [KW-1:0] op_s1;
	logic [KW-1:0] q_est;
	logic [KW-1:0] qn;
	logic [KW-1:0] r_full;
	logic [RAW:0]  r_n;

	// stage 1: quotient estimate product
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(op) * PW'(RECIP);
		op_s1   <= op;
	end

	// stage 2: remainder is below 2N, one subtract corrects it
	always_comb begin
		q_est  = KW'(prod_s1 >> SHIFT);
		qn     = KW'(q_est * KW'(NUM_BUCKETS));
		r_full = op_s1 - qn;
		r_n    = r_full[RAW:0];
		if (r_n >= NB_C) begin
			rem = RAW'(r_n - NB_C);
		end else begin
			rem = RAW'(r_n);
		end
	end

endmodule

[hw/rtl/bhs_row_mem.sv]
// Bucket row store: one row per bucket, all slot keys plus the slot-valid mask.
// Synchronous, registered read; per-row init flags stand in for a clear.
// Depends on bhs_pkg.
module bhs_row_mem #(
	parameter int NUM_BUCKETS  = bhs_pkg::NUM_BUCKETS_DEF,
	parameter int BUCKET_DEPTH = bhs_pkg::BUCKET_DEPTH_DEF,
	localparam int RAW   = $clog2(NUM_BUCKETS),
	localparam int ROW_W = BUCKET_DEPTH * bhs_pkg::KEY_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [RAW-1:0]          rd_addr,
	output logic [ROW_W-1:0]        rd_keys,
	output logic [BUCKET_DEPTH-1:0] rd_mask,
	input  logic                    wr_en,
	input  logic [RAW-1:0]          wr_addr,
	input  logic [ROW_W-1:0]        wr_keys,
	input  logic [BUCKET_DEPTH-1:0] wr_mask
);
	logic [ROW_W-1:0]        keys_mem [NUM_BUCKETS];
	logic [BUCKET_DEPTH-1:0] mask_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0]  init_q;
	logic                    rd_init_q;
	logic [ROW_W-1:0]        keys_rd_q;
	logic [BUCKET_DEPTH-1:0] mask_rd_q;

	// row storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			keys_mem[wr_addr] <= wr_keys;
			mask_mem[wr_addr] <= wr_mask;
		end
		if (rd_en) begin
			keys_rd_q <= keys_mem[rd_addr];
			mask_rd_q <= mask_mem[rd_addr];
		end
	end

	// a row never written reads as all slots empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= '0;
			rd_init_q <= 1'b0;
		end else begin
			if (wr_en) begin
				init_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= init_q[rd_addr];
			end
		end
	end

	assign rd_keys = keys_rd_q;
	assign rd_mask = mask_rd_q & {BUCKET_DEPTH{rd_init_q}};

endmodule

[hw/rtl/bucketed_hash_set_core.sv]
// Bucketed hash set core: insert, remove, alter and search on fixed-slot buckets.
// Insert, remove and search hash the key, read its row and finish on the compare; an
// alter reads the new key's row first and settles there (duplicate new key or same
// bucket), else reads the old row and fails there or moves the key (two reads, two
// writes). A new command is accepted only while idle, so commands never overlap.
// Results cannot be stalled. Reset empties every bucket at once.
module bucketed_hash_set_core #(
	parameter int NUM_BUCKETS  = bhs_pkg::NUM_BUCKETS_DEF,
	parameter int BUCKET_DEPTH = bhs_pkg::BUCKET_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic [bhs_pkg::KEY_W-1:0]  key_value,
	input  logic [bhs_pkg::KEY_W-1:0]  replacement_value,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [bhs_pkg::BIDX_W-1:0] bucket_index
);
	localparam int KW    = bhs_pkg::KEY_W;
	localparam int RAW   = $clog2(NUM_BUCKETS);
	localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int ROW_W = BUCKET_DEPTH * KW;

	bhs_pkg::state_t  state_q, state_d;
	bhs_pkg::cmd_t    cmd_q;
	bhs_pkg::status_t fin_status;
	bhs_pkg::status_t status_q;

	logic [KW-1:0]  key_q, repl_q, hash_op;
	logic [RAW-1:0] hash_rem, b_q, nb_q;
	logic           hash_sel;

	logic                    rd_en, wr_en;
	logic [RAW-1:0]          rd_addr, wr_addr;
	logic [ROW_W-1:0]        rd_keys, wr_keys;
	logic [BUCKET_DEPTH-1:0] rd_mask, wr_mask;

	// row analysis results
	logic          key_hit, repl_hit, free_any;
	logic [SW-1:0] key_pos, free_pos;

	// saved new-key row for a cross-bucket alter
	logic [ROW_W-1:0]        a_keys_q;
	logic [BUCKET_DEPTH-1:0] a_mask_q;
	logic [SW-1:0]           a_free_q;
	logic                    a_full_q;
	logic                    save_a;

	logic                 fin;
	logic                 done_q;
	logic [RAW-1:0]       bidx_q;
	logic                 accept;

	assign busy   = (state_q != bhs_pkg::S_IDLE);
	assign accept = start && !busy;

	// shared hash unit: old key first, then new key
	assign hash_op = hash_sel ? repl_q : key_q;

	bhs_hash #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_hash (
		.clk(clk),
		.op (hash_op),
		.rem(hash_rem)
	);

	bhs_row_mem #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.BUCKET_DEPTH(BUCKET_DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_keys(rd_keys),
		.rd_mask(rd_mask),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_keys(wr_keys),
		.wr_mask(wr_mask)
	);

	// slot compares on the row just read; lowest slot wins
	always_comb begin
		key_hit  = 1'b0;
		repl_hit = 1'b0;
		free_any = 1'b0;
		key_pos  = '0;
		free_pos = '0;
		for (int s = BUCKET_DEPTH - 1; s >= 0; s--) begin
			if (rd_mask[s] && rd_keys[s*KW +: KW] == key_q) begin
				key_hit = 1'b1;
				key_pos = SW'(s);
			end
			if (rd_mask[s] && rd_keys[s*KW +: KW] == repl_q) begin
				repl_hit = 1'b1;
			end
			if (!rd_mask[s]) begin
				free_any = 1'b1;
				free_pos = SW'(s);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bhs_pkg::S_IDLE: begin
				if (accept) begin
					state_d = bhs_pkg::S_MUL_K;
				end
			end
			bhs_pkg::S_MUL_K: state_d = bhs_pkg::S_MUL_R;
			bhs_pkg::S_MUL_R: begin
				if (cmd_q == bhs_pkg::CMD_ALTER) begin
					state_d = bhs_pkg::S_RD_NB;
				end else begin
					state_d = bhs_pkg::S_CMP_B;
				end
			end
			bhs_pkg::S_RD_NB: state_d = bhs_pkg::S_CMP_NB;
			bhs_pkg::S_CMP_NB: begin
				if (repl_hit || nb_q == b_q) begin
					state_d = bhs_pkg::S_IDLE;
				end else begin
					state_d = bhs_pkg::S_CMP_B;
				end
			end
			bhs_pkg::S_CMP_B: begin
				if (cmd_q == bhs_pkg::CMD_ALTER && key_hit && !a_full_q) begin
					state_d = bhs_pkg::S_WR_NB;
				end else begin
					state_d = bhs_pkg::S_IDLE;
				end
			end
			bhs_pkg::S_WR_NB: state_d = bhs_pkg::S_IDLE;
			default: state_d = bhs_pkg::S_IDLE;
		endcase
	end

	// outputs: hash select, memory accesses, finish
	always_comb begin
		hash_sel   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = b_q;
		wr_en      = 1'b0;
		wr_addr    = b_q;
		wr_keys    = rd_keys;
		wr_mask    = rd_mask;
		fin        = 1'b0;
		fin_status = bhs_pkg::ST_OK;
		save_a     = 1'b0;
		case (state_q)
			bhs_pkg::S_MUL_R: begin
				hash_sel = 1'b1;
				if (cmd_q != bhs_pkg::CMD_ALTER) begin
					rd_en   = 1'b1;
					rd_addr = hash_rem;
				end
			end
			bhs_pkg::S_RD_NB: begin
				rd_en   = 1'b1;
				rd_addr = hash_rem;
			end
			bhs_pkg::S_CMP_NB: begin
				if (repl_hit) begin
					fin        = 1'b1;
					fin_status = bhs_pkg::ST_DUP;
				end else if (nb_q == b_q) begin
					// same bucket: overwrite the old key in place
					fin = 1'b1;
					if (!key_hit) begin
						fin_status = bhs_pkg::ST_ABSENT;
					end else begin
						wr_en                    = 1'b1;
						wr_keys[key_pos*KW +: KW] = repl_q;
					end
				end else begin
					save_a = 1'b1;
					rd_en  = 1'b1;
					rd_addr = b_q;
				end
			end
			bhs_pkg::S_CMP_B: begin
				case (cmd_q)
					bhs_pkg::CMD_INSERT: begin
						fin = 1'b1;
						if (key_hit) begin
							fin_status = bhs_pkg::ST_DUP;
						end else if (!free_any) begin
							fin_status = bhs_pkg::ST_FULL;
						end else begin
							wr_en                     = 1'b1;
							wr_keys[free_pos*KW +: KW] = key_q;
							wr_mask[free_pos]         = 1'b1;
						end
					end
					bhs_pkg::CMD_REMOVE: begin
						fin = 1'b1;
						if (!key_hit) begin
							fin_status = bhs_pkg::ST_ABSENT;
						end else begin
							wr_en            = 1'b1;
							wr_mask[key_pos] = 1'b0;
						end
					end
					bhs_pkg::CMD_ALTER: begin
						// cross bucket: free old slot, new row follows
						if (!key_hit) begin
							fin        = 1'b1;
							fin_status = bhs_pkg::ST_ABSENT;
						end else if (a_full_q) begin
							fin        = 1'b1;
							fin_status = bhs_pkg::ST_FULL;
						end else begin
							wr_en            = 1'b1;
							wr_mask[key_pos] = 1'b0;
						end
					end
					default: begin
						fin = 1'b1;
						if (!key_hit) begin
							fin_status = bhs_pkg::ST_ABSENT;
						end
					end
				endcase
			end
			bhs_pkg::S_WR_NB: begin
				fin                        = 1'b1;
				wr_en                      = 1'b1;
				wr_addr                    = nb_q;
				wr_keys                    = a_keys_q;
				wr_keys[a_free_q*KW +: KW] = repl_q;
				wr_mask                    = a_mask_q;
				wr_mask[a_free_q]          = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhs_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// transaction payload, bucket numbers, saved row, result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= bhs_pkg::cmd_t'(cmd);
			key_q  <= key_value;
			repl_q <= replacement_value;
		end
		if (state_q == bhs_pkg::S_MUL_R) begin
			b_q <= hash_rem;
		end
		if (state_q == bhs_pkg::S_RD_NB) begin
			nb_q <= hash_rem;
		end
		if (save_a) begin
			a_keys_q <= rd_keys;
			a_mask_q <= rd_mask;
			a_free_q <= free_pos;
			a_full_q <= !free_any;
		end
		if (fin) begin
			status_q <= fin_status;
			bidx_q   <= b_q;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign bucket_index = bhs_pkg::BIDX_W'(bidx_q);

endmodule
